>>> src/beq_pkg.sv
// ----------------------------------------------------------------------------
// beq_pkg
// Shared constants, codes and types of the stereo three-band biquad equalizer.
// ----------------------------------------------------------------------------
package beq_pkg;

	localparam int NUM_BANDS      = 3;
	localparam int NUM_CHANNELS   = 2;
	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 24;

	localparam int COEF_W    = 32;
	localparam int NUM_COEFS = 5;

	// Input and configuration field widths
	localparam int FUNC_W     = 2;
	localparam int CHAN_W     = 1;
	localparam int BSEL_W     = 2;
	localparam int CIDX_W     = 3;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;
	localparam int MASK_FIELD_W = 3;

	// Storage geometry
	localparam int COEF_DEPTH = NUM_BANDS * NUM_COEFS;
	localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
	localparam int HIST_DEPTH = NUM_BANDS * NUM_CHANNELS;
	localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int BAND_W     = $clog2(NUM_BANDS + 1);
	localparam int BIDX_W     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
	localparam int STEP_LAST  = NUM_COEFS + 1;
	localparam int STEP_W     = $clog2(STEP_LAST + 1);
	localparam int SLOT_W     = $clog2(NUM_COEFS);

	// Arithmetic widths
	localparam int PROD_W  = COEF_W + SAMPLE_BITS;
	localparam int ACC_RAW = PROD_W + 3;
	localparam int ACC_W   = (ACC_RAW > 64) ? 64 : ACC_RAW;

	localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

	// Coefficient slots
	localparam logic [SLOT_W-1:0] SLOT_B0 = SLOT_W'(0);
	localparam logic [SLOT_W-1:0] SLOT_B1 = SLOT_W'(1);
	localparam logic [SLOT_W-1:0] SLOT_B2 = SLOT_W'(2);
	localparam logic [SLOT_W-1:0] SLOT_A1 = SLOT_W'(3);
	localparam logic [SLOT_W-1:0] SLOT_A2 = SLOT_W'(4);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_EQ_ENABLE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_BAND_MASK = CFG_IDX_W'(1);

	typedef enum logic [FUNC_W-1:0] {
		FN_SAMPLE = 2'd0,
		FN_COEF   = 2'd1,
		FN_CLEAR  = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEXT,
		ST_RUN,
		ST_WRITE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic init;
		logic mul;
		logic acc;
		logic neg;
	} mac_ctl_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] x1;
		logic signed [SAMPLE_BITS-1:0] x2;
		logic signed [SAMPLE_BITS-1:0] y1;
		logic signed [SAMPLE_BITS-1:0] y2;
	} hist_t;

	localparam int HIST_W = $bits(hist_t);

endpackage

>>> src/beq_if.sv
// ----------------------------------------------------------------------------
// beq_if
// Channel interfaces: sample/command input, result output, register writes.
// ----------------------------------------------------------------------------
interface beq_in_if import beq_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic [FUNC_W-1:0]             func;
	logic [CHAN_W-1:0]             channel;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic [BSEL_W-1:0]             band_sel;
	logic [CIDX_W-1:0]             coef_index;
	logic signed [COEF_W-1:0]      coef_value;

	modport source (output valid, func, channel, sample_in, band_sel, coef_index,
		coef_value, input ready);
	modport sink (input valid, func, channel, sample_in, band_sel, coef_index,
		coef_value, output ready);
endinterface

interface beq_out_if import beq_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic [CHAN_W-1:0]             channel_out;
	logic                          clipped;

	modport source (output valid, sample_out, channel_out, clipped, input ready);
	modport sink (input valid, sample_out, channel_out, clipped, output ready);
endinterface

interface beq_cfg_if import beq_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/beq_ram.sv
// ----------------------------------------------------------------------------
// beq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module beq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/beq_mac.sv
// ----------------------------------------------------------------------------
// beq_mac
// Shared multiply-accumulate unit: one coefficient product per cycle into a
// wide accumulator, then round half up, shift and saturate to a sample.
// ----------------------------------------------------------------------------
module beq_mac import beq_pkg::*; (
	input  logic                          clk,
	input  mac_ctl_t                      ctl,
	input  logic signed [COEF_W-1:0]      coef,
	input  logic signed [SAMPLE_BITS-1:0] operand,
	output logic signed [SAMPLE_BITS-1:0] y,
	output logic                          clip
);

	localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SMAX =
		{{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;

	logic signed [PROD_W-1:0] prod_s1;
	logic                     neg_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  shifted;

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_s1 <= coef * operand;
			neg_s1  <= ctl.neg;
		end
	end

	assign prod_ext = ACC_W'(prod_s1);

	// feedback terms subtract
	always_ff @(posedge clk) begin
		if (ctl.init) begin
			acc_q <= RND;
		end else if (ctl.acc) begin
			acc_q <= neg_s1 ? (acc_q - prod_ext) : (acc_q + prod_ext);
		end
	end

	always_comb begin
		shifted = acc_q >>> COEF_FRAC_BITS;
		clip    = 1'b0;
		y       = shifted[SAMPLE_BITS-1:0];
		if (shifted > SMAX) begin
			y    = SMAX[SAMPLE_BITS-1:0];
			clip = 1'b1;
		end else if (shifted < SMIN) begin
			y    = SMIN[SAMPLE_BITS-1:0];
			clip = 1'b1;
		end
	end

endmodule

>>> src/stereo_three_band_biquad_eq.sv
// ----------------------------------------------------------------------------
// stereo_three_band_biquad_eq
// Stereo equalizer: three cascaded direct-form-I biquads per channel, with
// coefficients and filter history held in synchronous RAMs.
// ----------------------------------------------------------------------------
//  port      dir  word                                              handshake
//  cfg       in   index, data (eq_enable, band_enable_mask)         valid/ready
//  samples   in   func, channel, sample_in, band_sel, coef_index,   valid/ready
//                 coef_value
//  results   out  sample_out, channel_out, clipped                  valid/ready
//
//  Each enabled band reads its coefficients through the single coefficient RAM
//  read port, one coefficient per cycle into the shared multiplier; disabled
//  bands are skipped, and in bypass a sample goes straight to the output register.
//  Coefficient writes and history clears leave the sequencer idle.
//  Reset puts coefficients at pass-through (b0 = 1.0) and history at zero
//  through per-entry valid bits, so no clearing pass is needed.
//  A waiting result in the output register does not stop the next word from
//  being taken; only the end of the following sample waits for it.
// ----------------------------------------------------------------------------
module stereo_three_band_biquad_eq import beq_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	beq_cfg_if.sink     cfg,
	beq_in_if.sink      samples,
	beq_out_if.source   results
);

	// Control state
	state_t                  state_q, state_d;
	logic [BAND_W-1:0]       band_q;
	logic [STEP_W-1:0]       step_q;
	logic                    eq_enable_q;
	logic [NUM_BANDS-1:0]    mask_q;
	logic [COEF_DEPTH-1:0]   coef_vld_q;
	logic [HIST_DEPTH-1:0]   hist_vld_q;
	logic                    out_valid_q;

	// Item payload
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [CHAN_W-1:0]             chan_q;
	logic                          clip_q;
	hist_t                         hist_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic [CHAN_W-1:0]             out_chan_q;
	logic                          out_clip_q;

	// Read pipeline
	logic                coef_vld_s1;
	logic                hist_vld_s1;
	logic [SLOT_W-1:0]   slot_s1;

	// Sequencer outputs
	logic       in_accept;
	logic       step_clr;
	logic       step_inc;
	logic       band_inc;
	logic       hist_cap;
	logic       hist_we;
	logic       out_load;
	mac_ctl_t   mac_ctl;

	logic [BIDX_W-1:0]        band_idx;
	logic [SLOT_W-1:0]        slot_rd;
	logic [COEF_AW-1:0]       coef_raddr;
	logic [COEF_AW-1:0]       coef_waddr;
	logic                     coef_we;
	logic [COEF_W-1:0]        coef_rdata;
	logic [HIST_AW-1:0]       hist_addr;
	logic [HIST_W-1:0]        hist_rdata;
	hist_t                    hist_rd;
	hist_t                    hist_wr;
	logic signed [COEF_W-1:0]      coef_eff;
	logic signed [SAMPLE_BITS-1:0] operand;
	logic signed [SAMPLE_BITS-1:0] mac_y;
	logic                          mac_clip;
	logic                          sample_ok;

	assign cfg.ready     = 1'b1;
	assign samples.ready = (state_q == ST_IDLE);
	assign in_accept     = samples.valid && samples.ready;
	assign sample_ok     = (int'(samples.channel) < NUM_CHANNELS);

	assign band_idx  = band_q[BIDX_W-1:0];
	assign hist_addr = HIST_AW'(int'(band_idx) * NUM_CHANNELS + int'(chan_q));

	// Coefficient reads walk b0..a2 of the current band; later steps park on b0
	assign slot_rd    = (int'(step_q) < NUM_COEFS) ? step_q[SLOT_W-1:0] : SLOT_B0;
	assign coef_raddr = COEF_AW'(int'(band_idx) * NUM_COEFS + int'(slot_rd));
	assign coef_waddr = COEF_AW'(int'(samples.band_sel) * NUM_COEFS
		+ int'(samples.coef_index));
	assign coef_we    = in_accept && (samples.func == FN_COEF)
		&& (int'(samples.band_sel) < NUM_BANDS) && (int'(samples.coef_index) < NUM_COEFS);

	beq_ram #(
		.WIDTH (COEF_W),
		.DEPTH (COEF_DEPTH)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (samples.coef_value),
		.raddr (coef_raddr),
		.rdata (coef_rdata)
	);

	beq_ram #(
		.WIDTH (HIST_W),
		.DEPTH (HIST_DEPTH)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_addr),
		.wdata (hist_wr),
		.raddr (hist_addr),
		.rdata (hist_rdata)
	);

	assign hist_rd = hist_t'(hist_rdata);

	// New history: shift x in, shift the band output in
	always_comb begin
		hist_wr.x1 = sample_q;
		hist_wr.x2 = hist_q.x1;
		hist_wr.y1 = mac_y;
		hist_wr.y2 = hist_q.y1;
	end

	// Entries never written read as pass-through coefficients
	always_comb begin
		if (coef_vld_s1) begin
			coef_eff = coef_rdata;
		end else if (slot_s1 == SLOT_B0) begin
			coef_eff = COEF_ONE;
		end else begin
			coef_eff = '0;
		end
	end

	always_comb begin
		case (slot_s1)
			SLOT_B0: operand = sample_q;
			SLOT_B1: operand = hist_q.x1;
			SLOT_B2: operand = hist_q.x2;
			SLOT_A1: operand = hist_q.y1;
			SLOT_A2: operand = hist_q.y2;
			default: operand = '0;
		endcase
	end

	beq_mac u_mac (
		.clk     (clk),
		.ctl     (mac_ctl),
		.coef    (coef_eff),
		.operand (operand),
		.y       (mac_y),
		.clip    (mac_clip)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		step_clr    = 1'b0;
		step_inc    = 1'b0;
		band_inc    = 1'b0;
		hist_cap    = 1'b0;
		hist_we     = 1'b0;
		out_load    = 1'b0;
		mac_ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_accept && (samples.func == FN_SAMPLE) && sample_ok) begin
					state_d = eq_enable_q ? ST_NEXT : ST_FINISH;
				end
			end
			ST_NEXT: begin
				step_clr = 1'b1;
				if (int'(band_q) == NUM_BANDS) begin
					state_d = ST_FINISH;
				end else if (mask_q[band_idx]) begin
					state_d = ST_RUN;
				end else begin
					band_inc = 1'b1;
				end
			end
			ST_RUN: begin
				step_inc     = 1'b1;
				mac_ctl.init = (step_q == '0);
				hist_cap     = (int'(step_q) == 1);
				mac_ctl.mul  = (int'(step_q) >= 1) && (int'(step_q) <= NUM_COEFS);
				mac_ctl.neg  = (slot_s1 == SLOT_A1) || (slot_s1 == SLOT_A2);
				mac_ctl.acc  = (int'(step_q) >= 2);
				if (int'(step_q) == STEP_LAST) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				hist_we  = 1'b1;
				band_inc = 1'b1;
				state_d  = ST_NEXT;
			end
			ST_FINISH: begin
				if (!out_valid_q || results.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q <= '0;
			step_q <= '0;
		end else begin
			if (in_accept) begin
				band_q <= '0;
			end else if (band_inc) begin
				band_q <= band_q + BAND_W'(1);
			end
			if (step_clr) begin
				step_q <= '0;
			end else if (step_inc) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// Registers; mask bits above the field width always drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eq_enable_q <= 1'b1;
			for (int b = 0; b < NUM_BANDS; b++) begin
				mask_q[b] <= (b < MASK_FIELD_W);
			end
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_EQ_ENABLE: eq_enable_q <= cfg.data[0];
				CFG_BAND_MASK: begin
					for (int b = 0; b < NUM_BANDS; b++) begin
						mask_q[b] <= (b < MASK_FIELD_W) ? cfg.data[b % CFG_DATA_W] : 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Valid bits: a coefficient or history write marks its entry, a clear drops a band's history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
			hist_vld_q <= '0;
		end else begin
			if (coef_we) begin
				coef_vld_q[coef_waddr] <= 1'b1;
			end
			if (hist_we) begin
				hist_vld_q[hist_addr] <= 1'b1;
			end
			if (in_accept && (samples.func == FN_CLEAR)
				&& (int'(samples.band_sel) < NUM_BANDS)) begin
				for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
					hist_vld_q[HIST_AW'(int'(samples.band_sel) * NUM_CHANNELS + ch)] <= 1'b0;
				end
			end
		end
	end

	// Read-side pipeline: valid bits and slot follow the RAM latency
	always_ff @(posedge clk) begin
		coef_vld_s1 <= coef_vld_q[coef_raddr];
		hist_vld_s1 <= hist_vld_q[hist_addr];
		slot_s1     <= slot_rd;
		if (hist_cap) begin
			hist_q <= hist_vld_s1 ? hist_rd : '0;
		end
	end

	// Sample working register: input, then each enabled band output in turn
	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_q <= samples.sample_in;
			chan_q   <= samples.channel;
			clip_q   <= 1'b0;
		end else if (hist_we) begin
			sample_q <= mac_y;
			clip_q   <= clip_q | mac_clip;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sample_q <= sample_q;
			out_chan_q   <= chan_q;
			out_clip_q   <= clip_q;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.sample_out  = out_sample_q;
	assign results.channel_out = out_chan_q;
	assign results.clipped     = out_clip_q;

	// Checks
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || results.ready))
		else $error("result loaded over an untaken word");

	a_run_band: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> ((int'(band_q) < NUM_BANDS) && mask_q[band_idx]))
		else $error("band run out of range or disabled");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (int'(step_q) <= STEP_LAST))
		else $error("band step counter overran");

	a_cmd_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (samples.func != FN_SAMPLE)) |=> (state_q == ST_IDLE))
		else $error("command word left the sequencer busy");

	a_write_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		hist_we |-> ($past(state_q) == ST_RUN))
		else $error("history written without a finished band");

endmodule
